// File: rtl/exlex_pkg.sv
package exlex_pkg;

  // Lexer states
  typedef enum logic [2:0] {
    LEX_INITIAL  = 3'd0,
    LEX_DIGITS   = 3'd1,
    LEX_VARIABLE = 3'd2,
    LEX_NAME     = 3'd3,
    LEX_STRING   = 3'd4
  } lex_state_e;

  // Input item
  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;
    logic       token_drop;
    logic       last;
  } out_item_t;

  localparam logic [7:0] QUOTE_RESET = 8'h60;  // backtick
  localparam int unsigned NUM_OPS = 12;
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_USCORE  = 8'h5F;
  localparam logic [7:0] CHAR_LPAREN  = 8'h28;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [NUM_OPS-1:0][7:0] OP_CHARS = {
    8'h2E, 8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h5E,
    8'h28, 8'h29, 8'h2C, 8'h3F, 8'h3A, 8'h3D
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == 8'h60) || (c == 8'h27) || (c == 8'h22);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_OPS; i++) begin
      if (OP_CHARS[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// File: rtl/expression_lexer_top.sv
// Expression lexer: splits ASCII text into tokens, one character per input
// transfer. The input channel (in_valid_i/in_ready_o, in_item_i) carries a
// character or an end-of-text mark; the output channel (out_valid_o/
// out_ready_i, out_item_o) carries one result per transfer, with last set
// on the final result of each input item.
// The first result of an item passes through the input register and the
// output queue before it is offered. Most items give one result; a
// character that terminates a number, variable or name is classified twice
// by the single pass unit and gives two results. The sustained rate is one
// result per cycle while the output queue has room.
// A two-entry output queue separates the channels, so a new item is taken
// while earlier results still wait; when the receiver stalls the queue
// fills and in_ready_o drops until a result is taken.
// Reset (rst_ni low, asynchronous) empties the queue and the input stage and
// returns the lexer to its initial state with no token open.
module expression_lexer_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  exlex_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output exlex_pkg::out_item_t out_item_o
);

  logic                 res_free;
  logic                 res_push;
  exlex_pkg::out_item_t res;

  exlex_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .res_free_i (res_free),
    .res_push_o (res_push),
    .res_o      (res)
  );

  exlex_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_item_i (res),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/exlex_core.sv
module exlex_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  exlex_pkg::in_item_t in_item_i,
  input  logic                res_free_i,
  output logic                res_push_o,
  output exlex_pkg::out_item_t res_o
);

  exlex_pkg::in_item_t   item_q;
  logic                  item_valid_q;
  exlex_pkg::lex_state_e st_q, st_d;
  logic [7:0]            quote_q, quote_d;
  logic                  dot_q, dot_d;
  logic                  open_q, open_d;

  logic       fire, consumed;
  logic       skip, redo, adv, closes;
  logic [7:0] c, ch;

  assign c          = item_q.in_char;
  assign fire       = item_valid_q && res_free_i;
  assign consumed   = fire && !redo;
  assign in_ready_o = !item_valid_q || consumed;
  assign res_push_o = fire;

  // One classification pass over the held character
  always_comb begin
    st_d    = st_q;
    quote_d = quote_q;
    dot_d   = dot_q;
    open_d  = open_q;
    skip    = 1'b0;
    redo    = 1'b0;
    adv     = 1'b0;
    closes  = 1'b0;
    ch      = c;
    res_o   = '0;
    if (item_q.end_of_text) begin
      closes = open_q && ((st_q == exlex_pkg::LEX_DIGITS) ||
                          (st_q == exlex_pkg::LEX_VARIABLE) ||
                          (st_q == exlex_pkg::LEX_NAME));
      res_o.token_end  = closes;
      res_o.token_drop = open_q && !closes;
      res_o.last       = 1'b1;
      st_d    = exlex_pkg::LEX_INITIAL;
      quote_d = exlex_pkg::QUOTE_RESET;
      dot_d   = 1'b0;
      open_d  = 1'b0;
    end else begin
      unique case (st_q)
        exlex_pkg::LEX_DIGITS: begin
          if (c == exlex_pkg::CHAR_DOT) begin
            if (dot_q) begin
              skip = 1'b1; redo = 1'b1; adv = 1'b1;
            end
            dot_d = 1'b1;
          end else if (!exlex_pkg::is_digit(c)) begin
            skip = 1'b1; redo = 1'b1; adv = 1'b1;
          end
        end
        exlex_pkg::LEX_VARIABLE: begin
          if (!exlex_pkg::is_digit(c) && !exlex_pkg::is_alpha(c) &&
              (c != exlex_pkg::CHAR_USCORE) && (c != exlex_pkg::CHAR_DOLLAR)) begin
            skip = 1'b1; redo = 1'b1; adv = 1'b1;
          end else begin
            st_d = exlex_pkg::LEX_NAME;
          end
        end
        exlex_pkg::LEX_NAME: begin
          if (c == exlex_pkg::CHAR_LPAREN) begin
            adv = 1'b1;
          end else if (!exlex_pkg::is_digit(c) && !exlex_pkg::is_alpha(c) &&
                       (c != exlex_pkg::CHAR_USCORE)) begin
            skip = 1'b1; redo = 1'b1; adv = 1'b1;
          end
        end
        exlex_pkg::LEX_STRING: begin
          if (c == quote_q) adv = 1'b1;
        end
        default: begin
          st_d = exlex_pkg::LEX_INITIAL;
          if (exlex_pkg::is_space(c)) begin
            skip = 1'b1;
          end else if (exlex_pkg::is_digit(c)) begin
            st_d  = exlex_pkg::LEX_DIGITS;
            dot_d = 1'b0;
          end else if (c == exlex_pkg::CHAR_DOLLAR) begin
            st_d = exlex_pkg::LEX_VARIABLE;
          end else if (exlex_pkg::is_alpha(c)) begin
            if (c <= 8'h5A) ch = c + exlex_pkg::CASE_OFFSET;
            st_d = exlex_pkg::LEX_NAME;
          end else if (exlex_pkg::is_op(c)) begin
            adv = 1'b1;
          end else if (exlex_pkg::is_quote(c)) begin
            quote_d = c;
            st_d    = exlex_pkg::LEX_STRING;
          end
        end
      endcase

      if (!skip) open_d = 1'b1;
      res_o.out_char   = skip ? 8'h00 : ch;
      res_o.char_valid = !skip;
      res_o.token_end  = adv && (open_q || !skip);
      res_o.last       = !redo;
      if (adv) begin
        open_d = 1'b0;
        st_d   = exlex_pkg::LEX_INITIAL;
      end
    end
  end

  // Lexer state advances once per pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= exlex_pkg::LEX_INITIAL;
      quote_q <= exlex_pkg::QUOTE_RESET;
      dot_q   <= 1'b0;
      open_q  <= 1'b0;
    end else if (fire) begin
      st_q    <= st_d;
      quote_q <= quote_d;
      dot_q   <= dot_d;
      open_q  <= open_d;
    end
  end

  // Input register; a terminating character stays for its second pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      item_valid_q <= 1'b1;
    end else if (consumed) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_item_i;
  end

endmodule

// File: rtl/exlex_outq.sv
module exlex_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  exlex_pkg::out_item_t push_item_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output exlex_pkg::out_item_t out_item_o
);

  exlex_pkg::out_item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       pop;

  assign free_o      = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      if (push_i && !pop) count_q <= count_q + 2'd1;
      else if (pop && !push_i) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_item_i;
  end

endmodule
